// ----- hw/rtl/cpu80_pkg.sv -----
// Package for the 8080 subset executor: widths, opcode names, flag positions,
// the architectural state type and the memory request type.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package cpu80_pkg;

  // Width of the internal byte memory address; memory accesses use only these low bits.
  localparam int ADDRESS_BITS = 16;
  localparam int MEM_DEPTH    = 1 << ADDRESS_BITS;

  typedef logic [ADDRESS_BITS-1:0] addr_t;
  typedef logic [15:0]             word_t;
  typedef logic [7:0]              byte_t;

  // Command codes carried in the opcode field of an input transaction.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Flag bit positions.
  localparam int FLAG_C = 0;
  localparam int FLAG_P = 1;
  localparam int FLAG_Z = 2;
  localparam int FLAG_S = 3;

  // Register pair selector held in bits 5:4 of the pair opcodes.
  localparam logic [1:0] PAIR_BC = 2'd0;
  localparam logic [1:0] PAIR_DE = 2'd1;
  localparam logic [1:0] PAIR_HL = 2'd2;

  // Implemented opcodes.
  localparam byte_t OP_NOP    = 8'h00;
  localparam byte_t OP_LXI_B  = 8'h01;
  localparam byte_t OP_DCR_B  = 8'h05;
  localparam byte_t OP_MVI_B  = 8'h06;
  localparam byte_t OP_DAD_B  = 8'h09;
  localparam byte_t OP_MVI_C  = 8'h0E;
  localparam byte_t OP_LXI_D  = 8'h11;
  localparam byte_t OP_INX_D  = 8'h13;
  localparam byte_t OP_DAD_D  = 8'h19;
  localparam byte_t OP_LDAX_D = 8'h1A;
  localparam byte_t OP_LXI_H  = 8'h21;
  localparam byte_t OP_INX_H  = 8'h23;
  localparam byte_t OP_MVI_H  = 8'h26;
  localparam byte_t OP_DAD_H  = 8'h29;
  localparam byte_t OP_LXI_SP = 8'h31;
  localparam byte_t OP_MVI_M  = 8'h36;
  localparam byte_t OP_MOV_LA = 8'h6F;
  localparam byte_t OP_MOV_MA = 8'h77;
  localparam byte_t OP_MOV_AH = 8'h7C;
  localparam byte_t OP_POP_B  = 8'hC1;
  localparam byte_t OP_JNZ    = 8'hC2;
  localparam byte_t OP_JMP    = 8'hC3;
  localparam byte_t OP_PUSH_B = 8'hC5;
  localparam byte_t OP_RET    = 8'hC9;
  localparam byte_t OP_CALL   = 8'hCD;
  localparam byte_t OP_POP_D  = 8'hD1;
  localparam byte_t OP_OUT    = 8'hD3;
  localparam byte_t OP_PUSH_D = 8'hD5;
  localparam byte_t OP_POP_H  = 8'hE1;
  localparam byte_t OP_PUSH_H = 8'hE5;
  localparam byte_t OP_XCHG   = 8'hEB;
  localparam byte_t OP_CPI    = 8'hFE;

  // Full architectural state, also the payload of one result transaction.
  typedef struct packed {
    word_t       pc;
    word_t       sp;
    byte_t       a;
    byte_t       b;
    byte_t       c;
    byte_t       d;
    byte_t       e;
    byte_t       h;
    byte_t       l;
    logic [3:0]  flags;
    logic        halted;
  } arch_t;

  // One access to the byte memory.
  typedef struct packed {
    logic  en;
    logic  we;
    addr_t addr;
    byte_t wdata;
  } mem_req_t;

  // Sign, zero and even parity from a result byte, with the carry supplied.
  function automatic logic [3:0] zsp_flags(input byte_t r, input logic carry);
    logic [3:0] f;
    begin
      f         = '0;
      f[FLAG_C] = carry;
      f[FLAG_P] = ~^r;
      f[FLAG_Z] = (r == 8'h00);
      f[FLAG_S] = r[7];
      return f;
    end
  endfunction

endpackage

// ----- hw/rtl/cpu80_if.sv -----
// Channel interfaces of the 8080 subset executor: command channel and status channel.
// Depends on cpu80_pkg for field types.
`timescale 1ns / 1ps

interface cpu80_cmd_if import cpu80_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  opcode;
  word_t load_address;
  byte_t load_data;

  modport source (output valid, output opcode, output load_address, output load_data,
                  input ready);
  modport sink   (input valid, input opcode, input load_address, input load_data,
                  output ready);
endinterface

interface cpu80_status_if import cpu80_pkg::*; ();
  logic       valid;
  logic       ready;
  word_t      prog_counter;
  word_t      stack_pointer;
  byte_t      acc;
  byte_t      reg_b;
  byte_t      reg_c;
  byte_t      reg_d;
  byte_t      reg_e;
  byte_t      reg_h;
  byte_t      reg_l;
  logic [3:0] flag_bits;
  logic       halted;

  modport source (output valid, output prog_counter, output stack_pointer, output acc,
                  output reg_b, output reg_c, output reg_d, output reg_e, output reg_h,
                  output reg_l, output flag_bits, output halted, input ready);
  modport sink   (input valid, input prog_counter, input stack_pointer, input acc,
                  input reg_b, input reg_c, input reg_d, input reg_e, input reg_h,
                  input reg_l, input flag_bits, input halted, output ready);
endinterface

// ----- hw/rtl/cpu80_ram.sv -----
// Single-port synchronous byte memory with a registered read, one access per cycle.
// Depends on cpu80_pkg for the depth and the request type.
`timescale 1ns / 1ps

module cpu80_ram import cpu80_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output byte_t    rdata
);

  byte_t mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end

endmodule

// ----- hw/rtl/cpu80_ctrl.sv -----
// Sequencer of the 8080 subset executor: clearing pass, fetch, execute and data accesses.
// Holds the architectural registers; depends on cpu80_pkg and the command interface.
`timescale 1ns / 1ps

module cpu80_ctrl import cpu80_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  cpu80_cmd_if.sink       cmd,
  output mem_req_t        mem_req,
  input  byte_t           mem_rdata,
  input  logic            res_free,
  output logic            res_load,
  output arch_t           arch
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_F0    = 3'd2;
  localparam logic [2:0] S_F1    = 3'd3;
  localparam logic [2:0] S_F2    = 3'd4;
  localparam logic [2:0] S_DATA1 = 3'd5;
  localparam logic [2:0] S_DATA2 = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state, state_next;
  addr_t      clr_addr, clr_addr_next;
  arch_t      arch_next;
  byte_t      op, op_next;
  byte_t      b1, b1_next;
  byte_t      b2, b2_next;

  word_t       pc1, pc2, pc3, bc, de, hl, imm16;
  word_t       spm1, spm2, spp1, spp2, dad_opnd;
  logic [16:0] dad_sum;
  byte_t       dcr_res, cpi_res, push_hi, push_lo;

  assign pc1   = arch.pc + 16'd1;
  assign pc2   = arch.pc + 16'd2;
  assign pc3   = arch.pc + 16'd3;
  assign bc    = {arch.b, arch.c};
  assign de    = {arch.d, arch.e};
  assign hl    = {arch.h, arch.l};
  assign imm16 = {mem_rdata, b1};
  assign spm1  = arch.sp - 16'd1;
  assign spm2  = arch.sp - 16'd2;
  assign spp1  = arch.sp + 16'd1;
  assign spp2  = arch.sp + 16'd2;

  assign dcr_res = arch.b - 8'd1;
  assign cpi_res = arch.a - b1;
  assign dad_sum = {1'b0, hl} + {1'b0, dad_opnd};

  always_comb begin
    case (op[5:4])
      PAIR_BC: begin
        dad_opnd = bc;
        push_hi  = arch.b;
        push_lo  = arch.c;
      end
      PAIR_DE: begin
        dad_opnd = de;
        push_hi  = arch.d;
        push_lo  = arch.e;
      end
      default: begin
        dad_opnd = hl;
        push_hi  = arch.h;
        push_lo  = arch.l;
      end
    endcase
  end

  assign cmd.ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    arch_next     = arch;
    op_next       = op;
    b1_next       = b1;
    b2_next       = b2;
    mem_req       = '0;
    res_load      = 1'b0;

    case (state)
      S_CLEAR: begin
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.addr  = clr_addr;
        mem_req.wdata = 8'h00;
        clr_addr_next = clr_addr + addr_t'(1);
        if (clr_addr == '1) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (cmd.valid) begin
          if (cmd.opcode == CMD_LOAD) begin
            mem_req.en    = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = cmd.load_address[ADDRESS_BITS-1:0];
            mem_req.wdata = cmd.load_data;
            state_next    = S_DONE;
          end else if (arch.halted) begin
            state_next = S_DONE;
          end else begin
            mem_req.en   = 1'b1;
            mem_req.addr = arch.pc[ADDRESS_BITS-1:0];
            state_next   = S_F0;
          end
        end
      end

      S_F0: begin
        op_next      = mem_rdata;
        mem_req.en   = 1'b1;
        mem_req.addr = pc1[ADDRESS_BITS-1:0];
        state_next   = S_F1;
      end

      S_F1: begin
        b1_next      = mem_rdata;
        mem_req.en   = 1'b1;
        mem_req.addr = pc2[ADDRESS_BITS-1:0];
        state_next   = S_F2;
      end

      S_F2: begin
        // mem_rdata is the second operand byte here.
        b2_next      = mem_rdata;
        arch_next.pc = pc1;
        state_next   = S_DONE;
        case (op)
          OP_NOP: begin
          end
          OP_LXI_B: begin
            arch_next.b  = mem_rdata;
            arch_next.c  = b1;
            arch_next.pc = pc3;
          end
          OP_LXI_D: begin
            arch_next.d  = mem_rdata;
            arch_next.e  = b1;
            arch_next.pc = pc3;
          end
          OP_LXI_H: begin
            arch_next.h  = mem_rdata;
            arch_next.l  = b1;
            arch_next.pc = pc3;
          end
          OP_LXI_SP: begin
            arch_next.sp = imm16;
            arch_next.pc = pc3;
          end
          OP_DCR_B: begin
            arch_next.b     = dcr_res;
            arch_next.flags = zsp_flags(dcr_res, arch.flags[FLAG_C]);
          end
          OP_MVI_B: begin
            arch_next.b  = b1;
            arch_next.pc = pc2;
          end
          OP_MVI_C: begin
            arch_next.c  = b1;
            arch_next.pc = pc2;
          end
          OP_MVI_H: begin
            arch_next.h  = b1;
            arch_next.pc = pc2;
          end
          OP_MVI_M: begin
            mem_req.en    = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = hl[ADDRESS_BITS-1:0];
            mem_req.wdata = b1;
            arch_next.pc  = pc2;
          end
          OP_DAD_B, OP_DAD_D, OP_DAD_H: begin
            arch_next.h             = dad_sum[15:8];
            arch_next.l             = dad_sum[7:0];
            arch_next.flags[FLAG_C] = dad_sum[16];
          end
          OP_INX_D: begin
            {arch_next.d, arch_next.e} = de + 16'd1;
          end
          OP_INX_H: begin
            {arch_next.h, arch_next.l} = hl + 16'd1;
          end
          OP_LDAX_D: begin
            mem_req.en   = 1'b1;
            mem_req.addr = de[ADDRESS_BITS-1:0];
            state_next   = S_DATA1;
          end
          OP_MOV_LA: begin
            arch_next.l = arch.a;
          end
          OP_MOV_MA: begin
            mem_req.en    = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = hl[ADDRESS_BITS-1:0];
            mem_req.wdata = arch.a;
          end
          OP_MOV_AH: begin
            arch_next.a = arch.h;
          end
          OP_POP_B, OP_POP_D, OP_POP_H, OP_RET: begin
            mem_req.en   = 1'b1;
            mem_req.addr = arch.sp[ADDRESS_BITS-1:0];
            state_next   = S_DATA1;
          end
          OP_PUSH_B, OP_PUSH_D, OP_PUSH_H: begin
            mem_req.en    = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = spm1[ADDRESS_BITS-1:0];
            mem_req.wdata = push_hi;
            state_next    = S_DATA1;
          end
          OP_CALL: begin
            // The return address still needs the old pc, so pc moves in the next state.
            mem_req.en    = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = spm1[ADDRESS_BITS-1:0];
            mem_req.wdata = pc3[15:8];
            arch_next.pc  = arch.pc;
            state_next    = S_DATA1;
          end
          OP_JNZ: begin
            arch_next.pc = arch.flags[FLAG_Z] ? pc3 : imm16;
          end
          OP_JMP: begin
            arch_next.pc = imm16;
          end
          OP_OUT: begin
            arch_next.pc = pc2;
          end
          OP_XCHG: begin
            arch_next.d = arch.h;
            arch_next.e = arch.l;
            arch_next.h = arch.d;
            arch_next.l = arch.e;
          end
          OP_CPI: begin
            arch_next.flags = zsp_flags(cpi_res, arch.a < b1);
            arch_next.pc    = pc2;
          end
          default: begin
            arch_next.halted = 1'b1;
          end
        endcase
      end

      S_DATA1: begin
        state_next = S_DONE;
        case (op)
          OP_LDAX_D: begin
            arch_next.a = mem_rdata;
          end
          OP_POP_B, OP_POP_D, OP_POP_H, OP_RET: begin
            // Low byte is parked in b1 until the high byte arrives.
            b1_next      = mem_rdata;
            mem_req.en   = 1'b1;
            mem_req.addr = spp1[ADDRESS_BITS-1:0];
            state_next   = S_DATA2;
          end
          OP_PUSH_B, OP_PUSH_D, OP_PUSH_H: begin
            mem_req.en    = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = spm2[ADDRESS_BITS-1:0];
            mem_req.wdata = push_lo;
            arch_next.sp  = spm2;
          end
          OP_CALL: begin
            mem_req.en    = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = spm2[ADDRESS_BITS-1:0];
            mem_req.wdata = pc3[7:0];
            arch_next.sp  = spm2;
            arch_next.pc  = {b2, b1};
          end
          default: begin
          end
        endcase
      end

      S_DATA2: begin
        state_next   = S_DONE;
        arch_next.sp = spp2;
        case (op)
          OP_POP_B: begin
            arch_next.b = mem_rdata;
            arch_next.c = b1;
          end
          OP_POP_D: begin
            arch_next.d = mem_rdata;
            arch_next.e = b1;
          end
          OP_POP_H: begin
            arch_next.h = mem_rdata;
            arch_next.l = b1;
          end
          default: begin
            arch_next.pc = {mem_rdata, b1};
          end
        endcase
      end

      S_DONE: begin
        if (res_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      arch     <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      arch     <= arch_next;
    end
  end

  always_ff @(posedge clk) begin
    op <= op_next;
    b1 <= b1_next;
    b2 <= b2_next;
  end

  // Once halted, only a reset brings the core back.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    arch.halted |=> arch.halted)
    else $error("halt flag cleared without reset");

  // A halted core writes memory only for a load transaction or the clearing pass.
  a_halt_no_store: assert property (@(posedge clk) disable iff (rst)
    (arch.halted && mem_req.en && mem_req.we) |-> (state == S_IDLE || state == S_CLEAR))
    else $error("memory written by a step of a halted core");

  // Flags change only in the execute state.
  a_flags_exec_only: assert property (@(posedge clk) disable iff (rst)
    (state != S_F2) |=> (arch.flags == $past(arch.flags)))
    else $error("flags changed outside execute");

  // A result is handed over only when the status register can take it.
  a_result_slot: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (res_free && state == S_DONE))
    else $error("result issued while status register is full");

endmodule

// ----- hw/rtl/cpu8080_subset_executor.sv -----
// Top level of the 8080 subset executor: byte memory, sequencer and status register.
// Depends on cpu80_pkg, cpu80_if, cpu80_ram and cpu80_ctrl.
`timescale 1ns / 1ps

// This block runs a subset of the 8080 instruction set against an internal byte
// memory of 2^ADDRESS_BITS entries. A command transaction either loads one memory
// byte (opcode 0) or executes the instruction at the program counter (opcode 1), and
// every command yields exactly one status transaction carrying the whole register
// state afterwards. After reset the block sweeps the memory to zero, one byte per
// cycle; commands are not accepted until the sweep ends. All state lives in one
// single-port synchronous memory with a registered read, so each instruction reads
// its opcode and two operand bytes in successive accesses, followed by at most two
// data or stack accesses. A load writes its byte on acceptance; a step passes
// S_F0, S_F1 and S_F2, then S_DATA1 for LDAX, PUSH and CALL, or S_DATA1 and
// S_DATA2 for POP and RET; a step of a halted core does neither. All then wait
// in S_DONE for a free status register. Commands are handled one at a time, but
// the status register lets the next command be accepted while the previous status
// transaction still waits to be taken. Unimplemented opcodes set the halt flag and
// advance the program counter by one; after that, steps change nothing, while loads
// still write memory. The auxiliary carry flag and real I/O are not modelled.

module cpu8080_subset_executor import cpu80_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  cpu80_cmd_if.sink     cmd,
  cpu80_status_if.source status
);

  mem_req_t mem_req;
  byte_t    mem_rdata;
  logic     res_free;
  logic     res_load;
  arch_t    arch;

  logic     status_valid;
  arch_t    result;

  cpu80_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  cpu80_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_free  (res_free),
    .res_load  (res_load),
    .arch      (arch)
  );

  // The status register is free when empty or when its transaction completes now.
  assign res_free = !status_valid || status.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else if (res_load) begin
      status_valid <= 1'b1;
    end else if (status.ready) begin
      status_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= arch;
    end
  end

  assign status.valid         = status_valid;
  assign status.prog_counter  = result.pc;
  assign status.stack_pointer = result.sp;
  assign status.acc           = result.a;
  assign status.reg_b         = result.b;
  assign status.reg_c         = result.c;
  assign status.reg_d         = result.d;
  assign status.reg_e         = result.e;
  assign status.reg_h         = result.h;
  assign status.reg_l         = result.l;
  assign status.flag_bits     = result.flags;
  assign status.halted        = result.halted;

endmodule
